FILE: sv/pgf_pkg.sv
`default_nettype none

package pgf_pkg;

  // Line store depth: the widest row the block can hold
  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int COL_W     = $clog2(MAX_WIDTH + 1);

  localparam int PIX_W     = 8;
  localparam int FW_W      = 11;
  localparam int FH_W      = 12;
  localparam int ROW_W     = FH_W;
  localparam int OROW_W    = FH_W + 1;
  localparam int CFG_W     = FH_W;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam int MIN_DIM      = 3;
  localparam int MAX_HEIGHT   = 4095;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [PIX_W-1:0] pix_t;

  // 3x3 window, index row*3 + col, row 0 top, col 0 left
  typedef logic [8:0][PIX_W-1:0] win_t;

  // Per-item control decided when the pixel is taken in
  typedef struct packed {
    logic access;
    logic emit;
    logic border;
    logic frame_done;
  } ctrl_t;

  typedef struct packed {
    pix_t gradient;
    logic frame_end;
  } result_t;

  // L1 Prewitt magnitude, saturated to the pixel range
  function automatic pix_t gradient3x3(input win_t w);
    logic [PIX_W+1:0] top;
    logic [PIX_W+1:0] bot;
    logic [PIX_W+1:0] lft;
    logic [PIX_W+1:0] rgt;
    logic [PIX_W+1:0] gy;
    logic [PIX_W+1:0] gx;
    logic [PIX_W+2:0] m;
    top = {2'b00, w[0]} + {2'b00, w[1]} + {2'b00, w[2]};
    bot = {2'b00, w[6]} + {2'b00, w[7]} + {2'b00, w[8]};
    lft = {2'b00, w[0]} + {2'b00, w[3]} + {2'b00, w[6]};
    rgt = {2'b00, w[2]} + {2'b00, w[5]} + {2'b00, w[8]};
    gy  = (bot >= top) ? (bot - top) : (top - bot);
    gx  = (lft >= rgt) ? (lft - rgt) : (rgt - lft);
    m   = {1'b0, gy} + {1'b0, gx};
    return (m > (PIX_W+3)'(255)) ? {PIX_W{1'b1}} : m[PIX_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/pgf_out_fifo.sv
`default_nettype none

module pgf_out_fifo (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire pgf_pkg::result_t             push_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output pgf_pkg::result_t                  out_data,
  output logic [pgf_pkg::FIFO_CNT_W-1:0]    count
);
  import pgf_pkg::*;

  result_t                 slot_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [FIFO_CNT_W-1:0]   cnt_r;
  logic                    pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = slot_r[rd_ptr_r];
  assign count     = cnt_r;
  assign pop       = out_valid && out_ready;

  // Store a result on push
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 :
                    wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 :
                    rd_ptr_r + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - FIFO_CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/prewitt_gradient_filter_3x3.sv
// Streaming 3x3 Prewitt gradient (L1 magnitude, saturated at 255) over 8-bit grey
// pixels in raster order. The block takes one pixel per clock while in_ready is
// high; a result is loaded into the three-entry output queue in the cycle after
// its pixel is taken and can be taken at the following edge. The rate is set by
// one read and one write of each line store per pixel; apart from the clear pass,
// in_ready drops only while three results are queued or about to be. The first
// width+1 pixels of a frame give no result; after the frame send width+1 pad items
// of any value, the last of which carries frame_end. The one-pixel frame border
// reads as 0. After reset the line stores are cleared one entry per cycle, all
// 1024 entries, while in_ready stays low. Write frame_width and frame_height only
// while the block is idle; values are clamped to 3..1024 and 3..4095.
`default_nettype none

module prewitt_gradient_filter_3x3 (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [pgf_pkg::PIX_W-1:0]     in_pixel,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pgf_pkg::PIX_W-1:0]          out_gradient,
  output logic                               out_frame_end,
  input  wire logic                          cfg_we,
  input  wire logic [pgf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pgf_pkg::CFG_W-1:0]     cfg_data
);
  import pgf_pkg::*;

  // Configuration (stored already clamped)
  logic [COL_W-1:0]  eff_w_r;
  logic [ROW_W-1:0]  eff_h_r;
  logic [FW_W-1:0]   cfg_w;
  logic [FH_W-1:0]   cfg_h;

  // Clear pass
  logic              clearing_r;
  logic [ADDR_W-1:0] clr_addr_r;

  // Position counters
  logic [COL_W-1:0]  in_col_r,  in_col_nxt;
  logic [ROW_W-1:0]  in_row_r,  in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;

  // Line stores
  pix_t              older_mem [MAX_WIDTH];
  pix_t              newer_mem [MAX_WIDTH];
  pix_t              rd_old_r;
  pix_t              rd_new_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  pix_t              mem_wd_old;
  pix_t              mem_wd_new;

  // Window stage
  logic              s1_valid_r;
  ctrl_t             s1_ctrl_r;
  logic [ADDR_W-1:0] s1_addr_r;
  pix_t              s1_pix_r;
  ctrl_t             ctrl_nxt;
  win_t              win_r, win_nxt;
  pix_t              top_px;
  pix_t              mid_px;

  logic              in_acc;
  logic              pad_row;
  logic [COL_W-1:0]  col_inc;
  logic [COL_W-1:0]  ocol_inc;
  logic [FIFO_CNT_W:0] pending;
  logic              push;
  result_t           push_data;
  result_t           fifo_out;
  logic [FIFO_CNT_W-1:0] fifo_cnt;

  assign cfg_w = cfg_data[FW_W-1:0];
  assign cfg_h = cfg_data[FH_W-1:0];

  // Take register writes, clamping to the legal frame size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= COL_W'(WIDTH_RESET);
      eff_h_r <= ROW_W'(HEIGHT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          if (int'(cfg_w) < MIN_DIM) begin
            eff_w_r <= COL_W'(MIN_DIM);
          end else if (int'(cfg_w) > MAX_WIDTH) begin
            eff_w_r <= COL_W'(MAX_WIDTH);
          end else begin
            eff_w_r <= COL_W'(cfg_w);
          end
        end
        REG_FRAME_HEIGHT: begin
          if (int'(cfg_h) < MIN_DIM) begin
            eff_h_r <= ROW_W'(MIN_DIM);
          end else if (int'(cfg_h) > MAX_HEIGHT) begin
            eff_h_r <= ROW_W'(MAX_HEIGHT);
          end else begin
            eff_h_r <= cfg_h;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold off input during the clear pass and while results in flight could overrun the output queue
  assign pending  = {1'b0, fifo_cnt} + (FIFO_CNT_W+1)'(s1_valid_r && s1_ctrl_r.emit);
  assign in_ready = !clearing_r && (pending < (FIFO_CNT_W+1)'(FIFO_DEPTH));
  assign in_acc   = in_valid && in_ready;

  // Decide access, emit, border and frame end, and the next counter values, from the counters
  assign pad_row  = (in_row_r >= eff_h_r);
  assign col_inc  = in_col_r + COL_W'(1);
  assign ocol_inc = out_col_r + COL_W'(1);

  always_comb begin
    ctrl_nxt.access     = (in_col_r < eff_w_r);
    ctrl_nxt.emit       = !((in_row_r == '0) ||
                            ((in_row_r == ROW_W'(1)) && (in_col_r == '0)));
    ctrl_nxt.frame_done = pad_row && (in_col_r >= eff_w_r);
    ctrl_nxt.border     = (out_row_r == '0) ||
                          ((out_row_r + OROW_W'(1)) >= OROW_W'(eff_h_r)) ||
                          (out_col_r == '0) || (ocol_inc >= eff_w_r);

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;

    if (pad_row) begin
      if (!ctrl_nxt.frame_done) begin
        in_col_nxt = col_inc;
      end
    end else if (col_inc >= eff_w_r) begin
      in_col_nxt = '0;
      in_row_nxt = in_row_r + ROW_W'(1);
    end else begin
      in_col_nxt = col_inc;
    end

    if (ctrl_nxt.emit) begin
      if (ocol_inc >= eff_w_r) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + OROW_W'(1);
      end else begin
        out_col_nxt = ocol_inc;
      end
    end

    if (ctrl_nxt.frame_done) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end
  end

  // Advance counters, clear pass and the window stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      s1_valid_r <= 1'b0;
      win_r      <= '0;
    end else begin
      if (clearing_r) begin
        if (clr_addr_r == ADDR_W'(MAX_WIDTH - 1)) begin
          clearing_r <= 1'b0;
        end
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (in_acc) begin
        in_col_r  <= in_col_nxt;
        in_row_r  <= in_row_nxt;
        out_col_r <= out_col_nxt;
        out_row_r <= out_row_nxt;
      end
      s1_valid_r <= in_acc;
      if (s1_valid_r) begin
        win_r <= win_nxt;
      end
    end
  end

  // Hold the taken pixel and its control for the window stage
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctrl_r <= ctrl_nxt;
      s1_addr_r <= in_col_r[ADDR_W-1:0];
      s1_pix_r  <= in_pixel;
    end
  end

  // Read both line stores at the incoming column
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_old_r <= older_mem[in_col_r[ADDR_W-1:0]];
      rd_new_r <= newer_mem[in_col_r[ADDR_W-1:0]];
    end
  end

  // Write back in the following cycle: shift the column up a row, or zero during clear
  assign mem_we     = clearing_r || (s1_valid_r && s1_ctrl_r.access);
  assign mem_wa     = clearing_r ? clr_addr_r : s1_addr_r;
  assign mem_wd_old = clearing_r ? '0 : rd_new_r;
  assign mem_wd_new = clearing_r ? '0 : s1_pix_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      older_mem[mem_wa] <= mem_wd_old;
      newer_mem[mem_wa] <= mem_wd_new;
    end
  end

  // Slide the window and compute the result
  assign top_px = s1_ctrl_r.access ? rd_old_r : '0;
  assign mid_px = s1_ctrl_r.access ? rd_new_r : '0;

  always_comb begin
    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = top_px;
    win_nxt[3] = win_r[4];
    win_nxt[4] = win_r[5];
    win_nxt[5] = mid_px;
    win_nxt[6] = win_r[7];
    win_nxt[7] = win_r[8];
    win_nxt[8] = s1_pix_r;
  end

  assign push                = s1_valid_r && s1_ctrl_r.emit;
  assign push_data.gradient  = s1_ctrl_r.border ? '0 : gradient3x3(win_nxt);
  assign push_data.frame_end = s1_ctrl_r.frame_done;

  pgf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (fifo_out),
    .count     (fifo_cnt)
  );

  assign out_gradient  = fifo_out.gradient;
  assign out_frame_end = fifo_out.frame_end;

endmodule

`default_nettype wire

FILE: sv/pgf_checker.sv
`default_nettype none

module pgf_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [pgf_pkg::PIX_W-1:0] out_gradient,
  input wire logic                      out_frame_end
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_gradient) && $stable(out_frame_end))
    else $error("stalled result changed");

  // Reset starts the line store clear, so no input is taken right after it
  a_reset_no_ready: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  // Reset empties the output queue
  a_reset_no_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // An empty output only fills from an earlier pixel transfer, passed through the window stage and the output queue
  a_out_from_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a prior transfer");

endmodule

bind prewitt_gradient_filter_3x3 pgf_checker u_pgf_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_prewitt_gradient_filter_3x3.sv
`timescale 1ns / 100ps

module tb_prewitt_gradient_filter_3x3;
  import pgf_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 16;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int RANDOM_PIXELS  = 2000;

  // Indexes past the two real registers; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum int {FILL_NOISE, FILL_EDGES, FILL_SMOOTH, FILL_FLAT} fill_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [PIX_W-1:0]     in_pixel = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [PIX_W-1:0]     out_gradient;
  logic                 out_frame_end;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  prewitt_gradient_filter_3x3 uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel     (in_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_gradient (out_gradient),
    .out_frame_end(out_frame_end),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Register copies seen by the predictor
  logic [FW_W-1:0] width_setting  = FW_W'(WIDTH_RESET);
  logic [FH_W-1:0] height_setting = FH_W'(HEIGHT_RESET);

  // Predictor state: two row stores, the window and the four position counters
  pix_t        older_row [MAX_WIDTH] = '{default: '0};
  pix_t        newer_row [MAX_WIDTH] = '{default: '0};
  win_t        window = '0;
  int unsigned in_col = 0;
  int unsigned in_line = 0;
  int unsigned out_col = 0;
  int unsigned out_line = 0;

  pix_t        pending_pixels [$];
  result_t     expected_gradients [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_hold = 0;
  int unsigned send_steady = 0;
  int unsigned recv_hold = 0;
  int unsigned recv_steady = 0;

  function automatic int unsigned active_width();
    if (width_setting < FW_W'(MIN_DIM)) return MIN_DIM;
    if (width_setting > FW_W'(MAX_WIDTH)) return MAX_WIDTH;
    return width_setting;
  endfunction

  function automatic int unsigned active_height();
    if (height_setting < FH_W'(MIN_DIM)) return MIN_DIM;
    if (height_setting > FH_W'(MAX_HEIGHT)) return MAX_HEIGHT;
    return height_setting;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none
  function automatic int unsigned next_gap(inout int unsigned steady);
    int unsigned r;
    if (steady != 0) begin
      steady--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 2) steady = $urandom_range(300, 40);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(30, 11);
  endfunction

  // Sender: hold the item until its transfer, then predict it and load the next
  always @(posedge clk) begin : drive_pixels
    int unsigned w, h;
    pix_t        top_pix, mid_pix;
    bit          pad_row, emit, frame_done, border;
    int          top_sum, bot_sum, left_sum, right_sum, gy, gx;
    result_t     r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        w = active_width();
        h = active_height();
        top_pix = '0;
        mid_pix = '0;
        pad_row = (in_line >= h);
        frame_done = 1'b0;

        // Read the column from both row stores and push the new pixel down
        if (in_col < w) begin
          top_pix = older_row[in_col];
          mid_pix = newer_row[in_col];
          older_row[in_col] = mid_pix;
          newer_row[in_col] = in_pixel;
        end
        window[0] = window[1]; window[1] = window[2]; window[2] = top_pix;
        window[3] = window[4]; window[4] = window[5]; window[5] = mid_pix;
        window[6] = window[7]; window[7] = window[8]; window[8] = in_pixel;

        emit = !(in_line == 0 || (in_line == 1 && in_col == 0));

        // Advance the input position; the pad row ends the frame at column width
        if (pad_row) begin
          if (in_col >= w) frame_done = 1'b1;
          else in_col++;
        end else begin
          in_col++;
          if (in_col >= w) begin
            in_col = 0;
            in_line++;
          end
        end

        if (emit) begin
          border = out_line == 0 || out_line + 1 >= h || out_col == 0 || out_col + 1 >= w;
          top_sum   = int'(window[0]) + int'(window[1]) + int'(window[2]);
          bot_sum   = int'(window[6]) + int'(window[7]) + int'(window[8]);
          left_sum  = int'(window[0]) + int'(window[3]) + int'(window[6]);
          right_sum = int'(window[2]) + int'(window[5]) + int'(window[8]);
          gy = bot_sum - top_sum;
          gx = left_sum - right_sum;
          if (gy < 0) gy = -gy;
          if (gx < 0) gx = -gx;
          if (border) r.gradient = '0;
          else if (gy + gx > 255) r.gradient = {PIX_W{1'b1}};
          else r.gradient = pix_t'(gy + gx);
          r.frame_end = frame_done;
          expected_gradients.push_back(r);
          out_col++;
          if (out_col >= w) begin
            out_col = 0;
            out_line++;
          end
        end

        if (frame_done) begin
          in_col = 0;
          in_line = 0;
          out_col = 0;
          out_line = 0;
        end
      end

      if (send_hold != 0) begin
        send_hold--;
        in_valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        in_valid <= 1'b1;
        in_pixel <= pending_pixels.pop_front();
        send_hold = next_gap(send_steady);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: check each transfer against the oldest prediction, stall at random
  always @(posedge clk) begin : take_results
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_gradients.size() == 0) begin
          $error("result with nothing predicted: gradient %0d frame_end %0b",
                 out_gradient, out_frame_end);
          mismatch_count++;
        end else begin
          want = expected_gradients.pop_front();
          if (out_gradient !== want.gradient) begin
            $error("gradient: expected %0d, actual %0d", want.gradient, out_gradient);
            mismatch_count++;
          end
          if (out_frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", want.frame_end, out_frame_end);
            mismatch_count++;
          end
        end
      end

      if (recv_hold != 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_ready && (out_valid || $urandom_range(15) == 0))
          recv_hold = next_gap(recv_steady);
      end
    end
  end

  // Give up on a hang
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_prewitt_gradient_filter_3x3 failed");
      $finish;
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_setting = value[FW_W-1:0];
    else if (idx == REG_FRAME_HEIGHT) height_setting = value[FH_W-1:0];
  endtask

  // Hold off until every queued pixel is taken and every result is back
  task automatic wait_drained();
    while (pending_pixels.size() != 0 || in_valid || expected_gradients.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Queue one frame at the current size followed by its width+1 pad items
  task automatic queue_frame(input fill_t fill, output int unsigned count);
    int unsigned w, h;
    pix_t        base, px;
    w = active_width();
    h = active_height();
    base = pix_t'($urandom);
    for (int unsigned i = 0; i < w * h; i++) begin
      case (fill)
        FILL_EDGES:  px = $urandom_range(1) ? {PIX_W{1'b1}} : '0;
        FILL_SMOOTH: px = base + pix_t'($urandom_range(6));
        FILL_FLAT:   px = base;
        default:     px = pix_t'($urandom);
      endcase
      pending_pixels.push_back(px);
    end
    for (int unsigned i = 0; i <= w; i++) pending_pixels.push_back(pix_t'($urandom));
    count = w * h + w + 1;
  endtask

  initial begin : stimulus
    pix_t                 bright_bottom [13] = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255,
                                                 8'd255, 8'd255, 8'd255,
                                                 8'd255, 8'd0, 8'd255, 8'd0};
    pix_t                 bright_top [13] = '{8'd20, 8'd30, 8'd40, 8'd0, 8'd0, 8'd0,
                                              8'd1, 8'd2, 8'd3,
                                              8'd0, 8'd255, 8'd0, 8'd255};
    int unsigned          random_pixels_sent;
    int unsigned          frame_items;
    int unsigned          frames;
    int unsigned          dim;
    logic [CFG_IDX_W-1:0] spare;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Let the row-store clearing pass finish
    while (!in_ready) @(posedge clk);

    // Directed: sizes below the minimum clamp to 3x3; saturated horizontal edge
    write_register(REG_FRAME_WIDTH, CFG_W'(0));
    write_register(REG_FRAME_HEIGHT, CFG_W'(2));
    write_register(REG_SPARE_A, {CFG_W{1'b1}});
    foreach (bright_bottom[i]) pending_pixels.push_back(bright_bottom[i]);
    wait_drained();

    // Directed: exact 3x3, both differences negative, no saturation
    write_register(REG_FRAME_WIDTH, CFG_W'(3));
    write_register(REG_FRAME_HEIGHT, CFG_W'(3));
    write_register(REG_SPARE_B, CFG_W'(1));
    foreach (bright_top[i]) pending_pixels.push_back(bright_top[i]);
    wait_drained();

    // Random: small frames, mostly back to back, sizes changed while drained
    random_pixels_sent = 0;
    while (random_pixels_sent < RANDOM_PIXELS) begin
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0:       dim = $urandom_range(2);
          1, 2:    dim = $urandom_range(40, 13);
          default: dim = $urandom_range(12, 3);
        endcase
        write_register(REG_FRAME_WIDTH, {1'($urandom_range(1)), FW_W'(dim)});
      end
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0:       dim = $urandom_range(2);
          1:       dim = $urandom_range(30, 11);
          default: dim = $urandom_range(10, 3);
        endcase
        write_register(REG_FRAME_HEIGHT, CFG_W'(dim));
      end
      if ($urandom_range(7) == 0) begin
        spare = $urandom_range(1) ? REG_SPARE_A : REG_SPARE_B;
        write_register(spare, CFG_W'($urandom));
      end
      frames = $urandom_range(3, 1);
      repeat (frames) begin
        queue_frame(fill_t'($urandom_range(3)), frame_items);
        random_pixels_sent += frame_items;
      end
      wait_drained();
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_prewitt_gradient_filter_3x3 passed");
    end else begin
      $display("tb_prewitt_gradient_filter_3x3 failed");
    end
    $finish;
  end

endmodule
